// File: rtl/sacl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants for the set-associative LRU cache tag model.
// ----------------------------------------------------------------------------
package sacl_pkg;

    localparam int TAG_W  = 64;
    localparam int AGE_W  = 3;
    localparam int META_W = AGE_W + 1;

    localparam logic [AGE_W-1:0] AGE_MAX = 3'd7;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_STORE  = 2'd1;
    localparam logic [1:0] CMD_MODIFY = 2'd2;
    localparam logic [1:0] CMD_FETCH  = 2'd3;

    localparam logic [1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [1:0] CFG_WAYS_USED  = 2'd2;

    typedef struct packed {
        logic hit;
        logic miss;
        logic evict;
    } t_acc_flags;

endpackage
`default_nettype wire

// File: rtl/sacl_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: rtl/sacl_way_logic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_way_logic
// Tag compare, victim choice and LRU age update for one set row.
// ----------------------------------------------------------------------------
module sacl_way_logic #(
    parameter int MAX_WAYS = 8
) (
    input  wire logic [MAX_WAYS*sacl_pkg::TAG_W-1:0]  i_tags,
    input  wire logic [MAX_WAYS*sacl_pkg::META_W-1:0] i_meta,
    input  wire logic [sacl_pkg::TAG_W-1:0]           i_tag,
    input  wire logic [$clog2(MAX_WAYS+1)-1:0]        i_nways,
    output logic      [MAX_WAYS*sacl_pkg::TAG_W-1:0]  o_tags,
    output logic      [MAX_WAYS*sacl_pkg::META_W-1:0] o_meta,
    output sacl_pkg::t_acc_flags                      o_flags
);
    import sacl_pkg::*;

    localparam int NW_W  = $clog2(MAX_WAYS + 1);
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    logic [MAX_WAYS-1:0] w_in_use;
    logic [MAX_WAYS-1:0] w_vld;
    logic [MAX_WAYS-1:0] w_hitv;
    logic [MAX_WAYS-1:0] w_freev;
    logic [MAX_WAYS-1:0] w_is_max;
    logic [AGE_W-1:0]    w_age [MAX_WAYS];
    logic [WAY_W-1:0]    w_hit_way;
    logic [WAY_W-1:0]    w_free_way;
    logic [WAY_W-1:0]    w_old_way;
    logic [WAY_W-1:0]    w_way;
    logic                w_hit;
    logic                w_found_free;
    logic                w_was_valid;
    logic [AGE_W-1:0]    w_old_age;

    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            w_in_use[i] = NW_W'(i) < i_nways;
            w_vld[i]    = i_meta[i*META_W + AGE_W];
            w_age[i]    = i_meta[i*META_W +: AGE_W];
            w_hitv[i]   = w_in_use[i] && w_vld[i] && (i_tags[i*TAG_W +: TAG_W] == i_tag);
            w_freev[i]  = w_in_use[i] && !w_vld[i];
        end
    end

    always_comb begin
        logic ok;
        for (int i = 0; i < MAX_WAYS; i++) begin
            ok = w_in_use[i];
            for (int j = 0; j < MAX_WAYS; j++) begin
                if (j != i && w_in_use[j]) begin
                    if (j < i && w_age[j] >= w_age[i]) begin
                        ok = 1'b0;
                    end
                    if (j > i && w_age[j] > w_age[i]) begin
                        ok = 1'b0;
                    end
                end
            end
            w_is_max[i] = ok;
        end
    end

    always_comb begin
        w_hit_way  = '0;
        w_free_way = '0;
        w_old_way  = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (w_hitv[i]) begin
                w_hit_way = WAY_W'(i);
            end
            if (w_freev[i]) begin
                w_free_way = WAY_W'(i);
            end
            if (w_is_max[i]) begin
                w_old_way = WAY_W'(i);
            end
        end
    end

    assign w_hit        = |w_hitv;
    assign w_found_free = |w_freev;
    assign w_way        = w_hit ? w_hit_way : (w_found_free ? w_free_way : w_old_way);
    assign w_was_valid  = w_hit || !w_found_free;

    always_comb begin
        w_old_age = '0;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (WAY_W'(i) == w_way) begin
                w_old_age = w_age[i];
            end
        end
    end

    always_comb begin
        o_tags = i_tags;
        o_meta = i_meta;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (WAY_W'(i) == w_way) begin
                o_tags[i*TAG_W +: TAG_W]   = i_tag;
                o_meta[i*META_W +: META_W] = {1'b1, {AGE_W{1'b0}}};
            end else if (w_in_use[i] && w_vld[i]) begin
                if ((!w_was_valid || w_age[i] < w_old_age) && w_age[i] < AGE_MAX) begin
                    o_meta[i*META_W +: AGE_W] = w_age[i] + AGE_W'(1);
                end
            end
        end
    end

    assign o_flags.hit   = w_hit;
    assign o_flags.miss  = !w_hit;
    assign o_flags.evict = !w_hit && !w_found_free;

endmodule
`default_nettype wire

// File: rtl/set_assoc_lru_cache_sim_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_top
// Tag-only set-associative cache with true LRU replacement and hit, miss and
// eviction totals.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with i_cmd and i_address while busy is low; the transaction
//   is taken at that edge. Load and store give one result, modify gives two
//   (the second a hit), instruction fetch gives none and leaves busy low.
//   Each result sits on the o_ ports for one cycle with o_strobe high;
//   o_last marks the final result of a transaction. The receiver cannot
//   stall, so results are never held back.
//   Timing: the set row is read at the accepting edge and its access runs in
//   ACC1; the result is registered onto the o_ ports at the end of ACC1. Each
//   access is one read-modify-write of a set row in the tag and age RAMs,
//   whose read port is registered. A modify runs its second access in ACC2
//   on the forwarded row, and its second result follows the first in the
//   next cycle.
//   The user is to write configuration (i_cfg_we, i_cfg_idx, i_cfg_data)
//   only while idle; the block does not enforce it. Reset: totals clear and
//   the age/valid RAM is swept, one set per cycle, over all 2**MAX_SET_BITS
//   sets with busy high; configuration writes are taken during the sweep.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim_top #(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [63:0] i_address,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [5:0]  i_cfg_data,
    output logic             o_strobe,
    output logic             o_hit,
    output logic             o_miss,
    output logic             o_evicted,
    output logic [31:0]      o_hit_total,
    output logic [31:0]      o_miss_total,
    output logic [31:0]      o_evict_total,
    output logic             o_last
);
    import sacl_pkg::*;

    localparam int NSETS  = 1 << MAX_SET_BITS;
    localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int NW_W   = $clog2(MAX_WAYS + 1);
    localparam int TROW_W = MAX_WAYS * TAG_W;
    localparam int MROW_W = MAX_WAYS * META_W;

    localparam logic [3:0]      SB_MAX   = 4'(MAX_SET_BITS);
    localparam logic [4:0]      WAYS_MAX = 5'(MAX_WAYS);
    localparam logic [SET_W-1:0] LAST_SET = SET_W'(NSETS - 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_ACC1  = 2'd2;
    localparam logic [1:0] ST_ACC2  = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [SET_W-1:0]  r_clr_idx;
    logic [3:0]        r_set_bits;
    logic [5:0]        r_block_bits;
    logic [3:0]        r_ways_used;
    logic [TAG_W-1:0]  r_tag;
    logic [SET_W-1:0]  r_set;
    logic              r_mod;
    logic [TROW_W-1:0] r_fwd_tags;
    logic [MROW_W-1:0] r_fwd_meta;
    logic              r_strobe;
    logic              r_hit;
    logic              r_miss;
    logic              r_evict;
    logic              r_last;
    logic [31:0]       r_hit_total;
    logic [31:0]       r_miss_total;
    logic [31:0]       r_evict_total;

    logic [3:0]        w_sb;
    logic [63:0]       w_shifted;
    logic [SET_W-1:0]  w_set;
    logic [6:0]        w_tag_sh;
    logic [TAG_W-1:0]  w_tag;
    logic [NW_W-1:0]   w_nways;
    logic [TROW_W-1:0] w_ram_tags;
    logic [MROW_W-1:0] w_ram_meta;
    logic [TROW_W-1:0] w_cur_tags;
    logic [MROW_W-1:0] w_cur_meta;
    logic [TROW_W-1:0] w_new_tags;
    logic [MROW_W-1:0] w_new_meta;
    logic              w_access;
    logic              w_meta_we;
    logic [SET_W-1:0]  w_meta_waddr;
    logic [MROW_W-1:0] w_meta_wdata;
    t_acc_flags        w_flags;

    // address split
    assign w_sb      = (r_set_bits > SB_MAX) ? SB_MAX : r_set_bits;
    assign w_shifted = i_address >> r_block_bits;
    assign w_set     = w_shifted[SET_W-1:0] & ~({SET_W{1'b1}} << w_sb);
    assign w_tag_sh  = {1'b0, r_block_bits} + {3'b000, w_sb};
    assign w_tag     = w_tag_sh[6] ? '0 : (i_address >> w_tag_sh[5:0]);

    always_comb begin
        if (r_ways_used == 4'd0) begin
            w_nways = NW_W'(1);
        end else if ({1'b0, r_ways_used} > WAYS_MAX) begin
            w_nways = NW_W'(MAX_WAYS);
        end else begin
            w_nways = NW_W'(r_ways_used);
        end
    end

    assign w_access   = (r_state == ST_ACC1) || (r_state == ST_ACC2);
    assign w_cur_tags = (r_state == ST_ACC2) ? r_fwd_tags : w_ram_tags;
    assign w_cur_meta = (r_state == ST_ACC2) ? r_fwd_meta : w_ram_meta;

    assign w_meta_we    = w_access || (r_state == ST_CLEAR);
    assign w_meta_waddr = (r_state == ST_CLEAR) ? r_clr_idx : r_set;
    assign w_meta_wdata = (r_state == ST_CLEAR) ? '0 : w_new_meta;

    sacl_ram #(
        .WIDTH (TROW_W),
        .DEPTH (NSETS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (w_access),
        .i_waddr (r_set),
        .i_wdata (w_new_tags),
        .i_raddr (w_set),
        .o_rdata (w_ram_tags)
    );

    sacl_ram #(
        .WIDTH (MROW_W),
        .DEPTH (NSETS)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (w_meta_we),
        .i_waddr (w_meta_waddr),
        .i_wdata (w_meta_wdata),
        .i_raddr (w_set),
        .o_rdata (w_ram_meta)
    );

    sacl_way_logic #(
        .MAX_WAYS (MAX_WAYS)
    ) u_way_logic (
        .i_tags  (w_cur_tags),
        .i_meta  (w_cur_meta),
        .i_tag   (r_tag),
        .i_nways (w_nways),
        .o_tags  (w_new_tags),
        .o_meta  (w_new_meta),
        .o_flags (w_flags)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_idx == LAST_SET) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start && i_cmd != CMD_FETCH) begin
                    n_state = ST_ACC1;
                end
            end
            ST_ACC1: begin
                n_state = r_mod ? ST_ACC2 : ST_IDLE;
            end
            ST_ACC2: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_clr_idx     <= '0;
            r_set_bits    <= 4'd4;
            r_block_bits  <= 6'd4;
            r_ways_used   <= 4'd1;
            r_strobe      <= 1'b0;
            r_hit_total   <= '0;
            r_miss_total  <= '0;
            r_evict_total <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= w_access;
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + SET_W'(1);
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SET_BITS:   r_set_bits   <= i_cfg_data[3:0];
                    CFG_BLOCK_BITS: r_block_bits <= i_cfg_data;
                    CFG_WAYS_USED:  r_ways_used  <= i_cfg_data[3:0];
                    default: begin
                    end
                endcase
            end
            if (w_access) begin
                if (w_flags.hit && r_hit_total != 32'hFFFF_FFFF) begin
                    r_hit_total <= r_hit_total + 32'd1;
                end
                if (w_flags.miss && r_miss_total != 32'hFFFF_FFFF) begin
                    r_miss_total <= r_miss_total + 32'd1;
                end
                if (w_flags.evict && r_evict_total != 32'hFFFF_FFFF) begin
                    r_evict_total <= r_evict_total + 32'd1;
                end
            end
        end
    end

    // hold the transaction and the forwarded row
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && start) begin
            r_tag <= w_tag;
            r_set <= w_set;
            r_mod <= (i_cmd == CMD_MODIFY);
        end
        if (w_access) begin
            r_fwd_tags <= w_new_tags;
            r_fwd_meta <= w_new_meta;
            r_hit      <= w_flags.hit;
            r_miss     <= w_flags.miss;
            r_evict    <= w_flags.evict;
            r_last     <= (r_state == ST_ACC2) || !r_mod;
        end
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_strobe      = r_strobe;
    assign o_hit         = r_hit;
    assign o_miss        = r_miss;
    assign o_evicted     = r_evict;
    assign o_hit_total   = r_hit_total;
    assign o_miss_total  = r_miss_total;
    assign o_evict_total = r_evict_total;
    assign o_last        = r_last;

endmodule
`default_nettype wire
